// ===== rtl/tiny_mlp_classifier_core_defines.svh =====
// Assertion macros shared by the checker of the classifier core.
`ifndef TINY_MLP_CLASSIFIER_CORE_DEFINES_SVH
`define TINY_MLP_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TMLP_ASSERT_IMPLIES(label, msg, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TMLP_ASSERT_NEXT(label, msg, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/tmlp_pkg.sv =====
// Types, constants and shared arithmetic of the classifier core.
package tmlp_pkg;

   localparam int FRAC_BITS    = 12;
   localparam int TANH_ENTRIES = 256;
   localparam int IDX_BITS     = $clog2(TANH_ENTRIES);
   localparam int IDX_SHIFT    = FRAC_BITS + 2 - IDX_BITS;
   localparam int ONE          = 1 << FRAC_BITS;
   localparam int LIMIT        = 4 << FRAC_BITS;
   localparam int WORD_W       = 16;
   localparam int ACT_W        = 14;
   localparam int PROD_W       = 32;
   localparam int SUM_W        = 34;
   localparam int BIAS_W       = 48;
   localparam int INDEX_W      = 4;
   localparam real TANH_STEP   = 4.0 / TANH_ENTRIES;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [ACT_W-1:0]  act_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [ACT_W-2:0]         tmag_type;
   typedef tmag_type                 tanh_lut_type [TANH_ENTRIES];

   typedef enum logic [INDEX_W-1:0] {
      CSR_W_H0_IN0  = 4'd0,
      CSR_W_H0_IN1  = 4'd1,
      CSR_W_H1_IN0  = 4'd2,
      CSR_W_H1_IN1  = 4'd3,
      CSR_W_OUT_H0  = 4'd4,
      CSR_W_OUT_H1  = 4'd5,
      CSR_BIAS_WORD = 4'd6,
      CSR_CLASS_CUT = 4'd7
   } csr_index_type;

   localparam word_type             W_H0_IN0_RST  = 16'sd3686;
   localparam word_type             W_H0_IN1_RST  = 16'sd2867;
   localparam word_type             W_H1_IN0_RST  = 16'sd6144;
   localparam word_type             W_H1_IN1_RST  = 16'sd2458;
   localparam word_type             W_OUT_H0_RST  = -16'sd1638;
   localparam word_type             W_OUT_H1_RST  = 16'sd3686;
   localparam logic [BIAS_W-1:0]    BIAS_WORD_RST = 48'hF99A_0333_FE66;
   localparam act_type              CLASS_CUT_RST = 14'sd410;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      word_type w_h0_in0;
      word_type w_h0_in1;
      word_type w_h1_in0;
      word_type w_h1_in1;
      word_type b_h0;
      word_type b_h1;
   } front_cfg_type;

   typedef struct packed {
      word_type w_out_h0;
      word_type w_out_h1;
      word_type b_out;
      act_type  cut;
   } back_cfg_type;

   typedef struct packed {
      act_type h0;
      act_type h1;
   } hidden_type;

   typedef struct packed {
      logic       empty;
      hidden_type data;
   } queue_out_type;

   // Table entry i holds the tanh magnitude at the centre of bin i.
   function automatic tanh_lut_type build_lut();
      tanh_lut_type lut;
      real          x;
      for (int i = 0; i < TANH_ENTRIES; i++) begin
         x      = (real'(i) + 0.5) * TANH_STEP;
         lut[i] = tmag_type'($rtoi(real'(ONE) * $tanh(x) + 0.5));
      end
      return lut;
   endfunction

   localparam tanh_lut_type TANH_LUT = build_lut();

   // Full-width sum of two products and a bias, floored by the fraction and
   // saturated to a signed word.
   function automatic word_type sum_sat(prod_type pa, prod_type pb, word_type bias);
      logic signed [SUM_W-1:0] s;
      logic signed [SUM_W-1:0] q;
      logic [SUM_W-WORD_W:0]   hi;
      s  = SUM_W'(pa) + SUM_W'(pb) + (SUM_W'(bias) <<< FRAC_BITS);
      q  = s >>> FRAC_BITS;
      hi = q[SUM_W-1:WORD_W-1];
      if ((&hi) || !(|hi)) begin
         return q[WORD_W-1:0];
      end else if (q[SUM_W-1]) begin
         return WORD_MIN;
      end else begin
         return WORD_MAX;
      end
   endfunction

   // Odd-symmetric table tanh, saturating to one at and beyond magnitude four.
   function automatic act_type tanh_act(word_type v);
      logic                     neg;
      logic signed [WORD_W:0]   ext;
      logic [WORD_W:0]          mag;
      tmag_type                 r;
      act_type                  sr;
      neg = v[WORD_W-1];
      ext = (WORD_W+1)'(v);
      mag = neg ? (WORD_W+1)'(-ext) : (WORD_W+1)'(ext);
      if (mag >= (WORD_W+1)'(LIMIT)) begin
         r = tmag_type'(ONE);
      end else begin
         r = TANH_LUT[mag[IDX_SHIFT +: IDX_BITS]];
      end
      sr = act_type'(r);
      return neg ? -sr : sr;
   endfunction

endpackage

// ===== rtl/tmlp_front.sv =====
// Front end: accepts feature items and computes the two hidden activations.
module tmlp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tmlp_pkg::word_type       req_feature0,
   input  tmlp_pkg::word_type       req_feature1,
   input  tmlp_pkg::front_cfg_type  cfg,
   input  logic                     q_full,
   output logic                     push,
   output tmlp_pkg::hidden_type     push_data
);

   logic                  advance;
   logic                  p_valid_ff;
   logic                  s_valid_ff;
   logic                  t_valid_ff;
   tmlp_pkg::prod_type    pa0_ff, pb0_ff, pa1_ff, pb1_ff;
   tmlp_pkg::prod_type    pa0_in, pb0_in, pa1_in, pb1_in;
   tmlp_pkg::word_type    s0_ff, s1_ff;
   tmlp_pkg::word_type    s0_in, s1_in;
   tmlp_pkg::hidden_type  t_ff;
   tmlp_pkg::hidden_type  t_in;

   // The whole pipe moves together; it holds only when its last item cannot
   // enter the queue.
   assign advance   = !(t_valid_ff && q_full);
   assign req_stall = !advance;
   assign push      = t_valid_ff && !q_full;
   assign push_data = t_ff;

   always_comb begin
      pa0_in  = tmlp_pkg::prod_type'(cfg.w_h0_in0) * tmlp_pkg::prod_type'(req_feature0);
      pb0_in  = tmlp_pkg::prod_type'(cfg.w_h0_in1) * tmlp_pkg::prod_type'(req_feature1);
      pa1_in  = tmlp_pkg::prod_type'(cfg.w_h1_in0) * tmlp_pkg::prod_type'(req_feature0);
      pb1_in  = tmlp_pkg::prod_type'(cfg.w_h1_in1) * tmlp_pkg::prod_type'(req_feature1);
      s0_in   = tmlp_pkg::sum_sat(pa0_ff, pb0_ff, cfg.b_h0);
      s1_in   = tmlp_pkg::sum_sat(pa1_ff, pb1_ff, cfg.b_h1);
      t_in.h0 = tmlp_pkg::tanh_act(s0_ff);
      t_in.h1 = tmlp_pkg::tanh_act(s1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= req_valid;
         s_valid_ff <= p_valid_ff;
         t_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa0_ff <= pa0_in;
         pb0_ff <= pb0_in;
         pa1_ff <= pa1_in;
         pb1_ff <= pb1_in;
         s0_ff  <= s0_in;
         s1_ff  <= s1_in;
         t_ff   <= t_in;
      end
   end

endmodule

// ===== rtl/tmlp_queue.sv =====
// Short queue of hidden activation pairs between the front and back ends.
module tmlp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tmlp_pkg::hidden_type      push_data,
   input  logic                      pop,
   output logic                      full,
   output tmlp_pkg::queue_out_type   q_out
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tmlp_pkg::hidden_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff,  count_in;

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign q_out.empty = (count_ff == '0);
   assign q_out.data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tmlp_back.sv =====
// Back end: output neuron, class decision and the result register.
module tmlp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  tmlp_pkg::queue_out_type  q_in,
   output logic                     pop,
   input  tmlp_pkg::back_cfg_type   cfg,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tmlp_pkg::act_type        rsp_score,
   output logic                     rsp_class_bit
);

   logic                 advance;
   logic                 p_valid_ff;
   logic                 s_valid_ff;
   logic                 o_valid_ff;
   tmlp_pkg::prod_type   pa_ff, pb_ff, pa_in, pb_in;
   tmlp_pkg::word_type   s_ff, s_in;
   tmlp_pkg::act_type    score_ff, score_in;
   logic                 class_ff, class_in;

   assign advance       = !(o_valid_ff && rsp_stall);
   assign pop           = advance && !q_in.empty;
   assign rsp_valid     = o_valid_ff;
   assign rsp_score     = score_ff;
   assign rsp_class_bit = class_ff;

   always_comb begin
      pa_in = tmlp_pkg::prod_type'(cfg.w_out_h0) * tmlp_pkg::prod_type'(q_in.data.h0);
      pb_in = tmlp_pkg::prod_type'(cfg.w_out_h1) * tmlp_pkg::prod_type'(q_in.data.h1);
      s_in     = tmlp_pkg::sum_sat(pa_ff, pb_ff, cfg.b_out);
      score_in = tmlp_pkg::tanh_act(s_ff);
      class_in = (score_in >= cfg.cut);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= !q_in.empty;
         s_valid_ff <= p_valid_ff;
         o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         s_ff     <= s_in;
         score_ff <= score_in;
         class_ff <= class_in;
      end
   end

endmodule

// ===== rtl/tiny_mlp_classifier_core.sv =====
// An item passes the front product, sum and tanh registers, the hidden-value
// queue, and the back product, sum and result registers. Throughput: one item
// per cycle; each pipe holds on its own and the queue absorbs the difference.
// Reset clears all pipe valid flags and the queue, and loads the weights,
// biases and class cut with their default values; no clearing pass is needed.
module tiny_mlp_classifier_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_feature0,
   input  logic signed [15:0]               req_feature1,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [13:0]               rsp_score,
   output logic                             rsp_class_bit,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [3:0]                       csr_index,
   input  logic [47:0]                      csr_data
);

   tmlp_pkg::word_type        w_h0_in0_ff, w_h0_in1_ff, w_h1_in0_ff, w_h1_in1_ff;
   tmlp_pkg::word_type        w_out_h0_ff, w_out_h1_ff;
   logic [tmlp_pkg::BIAS_W-1:0] bias_word_ff;
   tmlp_pkg::act_type         class_cut_ff;

   tmlp_pkg::front_cfg_type   front_cfg;
   tmlp_pkg::back_cfg_type    back_cfg;
   logic                      q_full;
   logic                      push;
   logic                      pop;
   tmlp_pkg::hidden_type      push_data;
   tmlp_pkg::queue_out_type   q_out;

   assign csr_ready = 1'b1;

   // Writes to indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         w_h0_in0_ff  <= tmlp_pkg::W_H0_IN0_RST;
         w_h0_in1_ff  <= tmlp_pkg::W_H0_IN1_RST;
         w_h1_in0_ff  <= tmlp_pkg::W_H1_IN0_RST;
         w_h1_in1_ff  <= tmlp_pkg::W_H1_IN1_RST;
         w_out_h0_ff  <= tmlp_pkg::W_OUT_H0_RST;
         w_out_h1_ff  <= tmlp_pkg::W_OUT_H1_RST;
         bias_word_ff <= tmlp_pkg::BIAS_WORD_RST;
         class_cut_ff <= tmlp_pkg::CLASS_CUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tmlp_pkg::CSR_W_H0_IN0:  w_h0_in0_ff  <= csr_data[15:0];
            tmlp_pkg::CSR_W_H0_IN1:  w_h0_in1_ff  <= csr_data[15:0];
            tmlp_pkg::CSR_W_H1_IN0:  w_h1_in0_ff  <= csr_data[15:0];
            tmlp_pkg::CSR_W_H1_IN1:  w_h1_in1_ff  <= csr_data[15:0];
            tmlp_pkg::CSR_W_OUT_H0:  w_out_h0_ff  <= csr_data[15:0];
            tmlp_pkg::CSR_W_OUT_H1:  w_out_h1_ff  <= csr_data[15:0];
            tmlp_pkg::CSR_BIAS_WORD: bias_word_ff <= csr_data;
            tmlp_pkg::CSR_CLASS_CUT: class_cut_ff <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      front_cfg.w_h0_in0 = w_h0_in0_ff;
      front_cfg.w_h0_in1 = w_h0_in1_ff;
      front_cfg.w_h1_in0 = w_h1_in0_ff;
      front_cfg.w_h1_in1 = w_h1_in1_ff;
      front_cfg.b_h0     = bias_word_ff[15:0];
      front_cfg.b_h1     = bias_word_ff[31:16];
      back_cfg.w_out_h0  = w_out_h0_ff;
      back_cfg.w_out_h1  = w_out_h1_ff;
      back_cfg.b_out     = bias_word_ff[47:32];
      back_cfg.cut       = class_cut_ff;
   end

   tmlp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_feature0 (req_feature0),
      .req_feature1 (req_feature1),
      .cfg          (front_cfg),
      .q_full       (q_full),
      .push         (push),
      .push_data    (push_data)
   );

   tmlp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .q_out     (q_out)
   );

   tmlp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_in          (q_out),
      .pop           (pop),
      .cfg           (back_cfg),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_score     (rsp_score),
      .rsp_class_bit (rsp_class_bit)
   );

endmodule

// ===== rtl/tmlp_checker.sv =====
// Port-level checks of the classifier core and their binding.
`include "tiny_mlp_classifier_core_defines.svh"

module tmlp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [13:0] rsp_score,
   input logic               rsp_class_bit
);

   logic       in_acc;
   logic       out_acc;
   logic [7:0] pending_ff, pending_in;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff + {7'd0, in_acc} - {7'd0, out_acc};
   end

   // Count of items taken in but not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `TMLP_ASSERT_NEXT(a_rsp_hold, "result changed while stalled", clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_score) && $stable(rsp_class_bit))
   `TMLP_ASSERT_IMPLIES(a_no_spurious, "result without an item in flight", clock, reset, rsp_valid, pending_ff != 8'd0)
   `TMLP_ASSERT_IMPLIES(a_score_range, "score outside plus or minus one", clock, reset, rsp_valid, (rsp_score <= 14'sd4096) && (rsp_score >= -14'sd4096))
   `TMLP_ASSERT_IMPLIES(a_reset_empty, "pipe not empty after reset", clock, reset, $fell(reset), !rsp_valid && !req_stall)

endmodule

bind tiny_mlp_classifier_core tmlp_checker u_checker (.*);

// ===== sim/tiny_mlp_classifier_core_tb.sv =====
// Self-checking testbench for the two-layer tanh classifier core.
module tiny_mlp_classifier_core_tb;
   import tmlp_pkg::*;

   localparam int ITEMS_PER_PHASE = 125;
   localparam int PHASES          = 9;
   localparam int STUCK_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 200;
   localparam int FIRST_SPARE     = int'(CSR_CLASS_CUT) + 1;
   localparam int LAST_SPARE      = (1 << INDEX_W) - 1;
   localparam logic [63:0] Q60_UNIT = 64'd1 << 60;

   typedef enum {
      SET_RESET, SET_MAX, SET_MIN, SET_ZERO, SET_MODERATE, SET_WILD, SET_CUT_HIGH, SET_CUT_LOW
   } setting_type;

   // Holds a copy of the registers, works out the score of every accepted item
   // and compares the results in order.
   class score_ledger_type;
      word_type          weight [6];
      logic [BIAS_W-1:0] bias_bits;
      act_type           cut;
      int                tanh_mag [TANH_ENTRIES];
      act_type           pending_score [$];
      logic              pending_class [$];
      int                errors;

      function new();
         weight[CSR_W_H0_IN0] = W_H0_IN0_RST;
         weight[CSR_W_H0_IN1] = W_H0_IN1_RST;
         weight[CSR_W_H1_IN0] = W_H1_IN0_RST;
         weight[CSR_W_H1_IN1] = W_H1_IN1_RST;
         weight[CSR_W_OUT_H0] = W_OUT_H0_RST;
         weight[CSR_W_OUT_H1] = W_OUT_H1_RST;
         bias_bits = BIAS_WORD_RST;
         cut       = CLASS_CUT_RST;
         errors    = 0;
         fill_tanh_table();
      endfunction

      // (a * b) >> 60 on Q60 fractions.
      function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = 128'(a) * 128'(b);
         return p[123:60];
      endfunction

      // Exact integer table: exp(-2x) stepped in Q60, tanh = (1 - e) / (1 + e), rounded.
      function void fill_tanh_table();
         logic [63:0] term, step, step2, e, a, b, num;
         term = Q60_UNIT;
         step = Q60_UNIT;
         for (int n = 1; n <= 40; n++) begin
            term = (term * 64'd4) / (64'(TANH_ENTRIES) * 64'(n));
            if (n % 2 == 1) begin
               step = step - term;
            end else begin
               step = step + term;
            end
         end
         step2 = q60_mul(step, step);
         e = step;
         for (int i = 0; i < TANH_ENTRIES; i++) begin
            a = (Q60_UNIT - e) >> 20;
            b = (Q60_UNIT + e) >> 20;
            num = ((a << FRAC_BITS) << 1) + b;
            tanh_mag[i] = int'(num / (b << 1));
            e = q60_mul(e, step2);
         end
      endfunction

      function act_type activate(word_type v);
         int m;
         int idx;
         int r;
         m = (v < 0) ? -int'(v) : int'(v);
         idx = m * TANH_ENTRIES / (4 << FRAC_BITS);
         r = (idx >= TANH_ENTRIES) ? ONE : tanh_mag[idx];
         return act_type'((v < 0) ? -r : r);
      endfunction

      function act_type neuron(word_type wa, word_type xa, word_type wb, word_type xb,
                               word_type bias);
         longint s;
         longint q;
         s = longint'(wa) * longint'(xa) + longint'(wb) * longint'(xb)
             + longint'(bias) * longint'(ONE);
         q = s >>> FRAC_BITS;
         if (q > longint'(WORD_MAX)) begin
            q = longint'(WORD_MAX);
         end else if (q < longint'(WORD_MIN)) begin
            q = longint'(WORD_MIN);
         end
         return activate(word_type'(q));
      endfunction

      function void load_register(logic [INDEX_W-1:0] idx, logic [BIAS_W-1:0] data);
         case (csr_index_type'(idx))
            CSR_W_H0_IN0, CSR_W_H0_IN1, CSR_W_H1_IN0,
            CSR_W_H1_IN1, CSR_W_OUT_H0, CSR_W_OUT_H1: weight[idx] = word_type'(data[15:0]);
            CSR_BIAS_WORD: bias_bits = data;
            CSR_CLASS_CUT: cut = act_type'(data[ACT_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_features(word_type f0, word_type f1);
         act_type h0;
         act_type h1;
         act_type sc;
         h0 = neuron(weight[CSR_W_H0_IN0], f0, weight[CSR_W_H0_IN1], f1,
                     word_type'(bias_bits[15:0]));
         h1 = neuron(weight[CSR_W_H1_IN0], f0, weight[CSR_W_H1_IN1], f1,
                     word_type'(bias_bits[31:16]));
         sc = neuron(weight[CSR_W_OUT_H0], word_type'(h0), weight[CSR_W_OUT_H1],
                     word_type'(h1), word_type'(bias_bits[47:32]));
         pending_score.push_back(sc);
         pending_class.push_back(sc >= cut);
      endfunction

      function void check_score(act_type got_score, logic got_class);
         act_type want_score;
         logic    want_class;
         if (pending_score.size() == 0) begin
            $display("%0t: result with no item waiting: score %0d class %0d",
                     $time, got_score, got_class);
            errors++;
            return;
         end
         want_score = pending_score.pop_front();
         want_class = pending_class.pop_front();
         if (got_score !== want_score) begin
            $display("%0t: score expected %0d, got %0d", $time, want_score, got_score);
            errors++;
         end
         if (got_class !== want_class) begin
            $display("%0t: class bit expected %0d, got %0d", $time, want_class, got_class);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   word_type            req_feature0;
   word_type            req_feature1;
   logic                rsp_valid;
   logic                rsp_stall;
   act_type             rsp_score;
   logic                rsp_class_bit;
   logic                csr_valid;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index;
   logic [BIAS_W-1:0]   csr_data;

   score_ledger_type book = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;

   tiny_mlp_classifier_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_feature0  (req_feature0),
      .req_feature1  (req_feature1),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_score     (rsp_score),
      .rsp_class_bit (rsp_class_bit),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            book.note_features(req_feature0, req_feature1);
         end
         if (rsp_valid && !rsp_stall) begin
            book.check_score(rsp_score, rsp_class_bit);
         end
      end
   end

   // The receiver stalls at random; a requested hold-off is counted down here.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            stuck = 0;
         end else begin
            stuck++;
         end
      end
      $display("tiny_mlp_classifier_core: mismatch");
      $finish;
   end

   function automatic word_type draw_feature();
      case ($urandom_range(3))
         0: return word_type'($urandom);
         1: return word_type'(int'($urandom_range(2048)) - 1024);
         default: return word_type'(int'($urandom_range(16384)) - 8192);
      endcase
   endfunction

   function automatic word_type draw_moderate(int span);
      return word_type'(int'($urandom_range(2 * span)) - span);
   endfunction

   // Valid stays high from one item to the next unless an idle gap is drawn.
   task automatic send_features(input word_type f0, input word_type f1);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_feature0 <= f0;
      req_feature1 <= f1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(input logic [INDEX_W-1:0] idx, input logic [BIAS_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      book.load_register(idx, data);
   endtask

   // One edge first, so that an item accepted at the last edge has been noted.
   task automatic wait_drained();
      @(posedge clock);
      while (book.pending_score.size() != 0) @(posedge clock);
   endtask

   // Writes every register; spare bits of the data are filled with noise.
   task automatic apply_setting(input setting_type kind);
      word_type          w [6];
      word_type          b [3];
      act_type           cut_v;
      logic [BIAS_W-1:0] raw;
      for (int i = 0; i < 6; i++) begin
         case (kind)
            SET_MAX:  w[i] = WORD_MAX;
            SET_MIN:  w[i] = WORD_MIN;
            SET_ZERO: w[i] = '0;
            SET_WILD: w[i] = word_type'($urandom);
            default:  w[i] = draw_moderate(8192);
         endcase
      end
      for (int k = 0; k < 3; k++) begin
         case (kind)
            SET_MAX:  b[k] = WORD_MAX;
            SET_MIN:  b[k] = WORD_MIN;
            SET_ZERO: b[k] = '0;
            SET_WILD: b[k] = word_type'($urandom);
            default:  b[k] = draw_moderate(4096);
         endcase
      end
      case (kind)
         SET_MAX:      cut_v = act_type'(ONE);
         SET_MIN:      cut_v = -act_type'(ONE);
         SET_ZERO:     cut_v = '0;
         SET_WILD:     cut_v = act_type'($urandom);
         SET_CUT_HIGH: cut_v = {1'b0, {(ACT_W-1){1'b1}}};
         SET_CUT_LOW:  cut_v = {1'b1, {(ACT_W-1){1'b0}}};
         default:      cut_v = act_type'(int'($urandom_range(2 * ONE)) - ONE);
      endcase
      for (int i = 0; i < 6; i++) begin
         raw = BIAS_W'({$urandom, $urandom});
         raw[WORD_W-1:0] = w[i];
         write_csr(INDEX_W'(int'(CSR_W_H0_IN0) + i), raw);
      end
      write_csr(CSR_BIAS_WORD, {b[2], b[1], b[0]});
      raw = BIAS_W'({$urandom, $urandom});
      raw[ACT_W-1:0] = cut_v;
      write_csr(CSR_CLASS_CUT, raw);
      // Writes to unused indexes must leave every register alone.
      for (int i = 0; i < 2; i++) begin
         write_csr(INDEX_W'($urandom_range(FIRST_SPARE, LAST_SPARE)),
                   BIAS_W'({$urandom, $urandom}));
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      setting_type plan [PHASES];
      word_type    corner_f0 [16];
      word_type    corner_f1 [16];
      plan = '{SET_RESET, SET_MODERATE, SET_MAX, SET_MIN, SET_WILD, SET_ZERO,
               SET_CUT_HIGH, SET_CUT_LOW, SET_MODERATE};
      corner_f0 = '{16'sd0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 16'sd1, 16'sd4096,
                    16'sd0, -16'sd4096, 16'sd16384, 16'sd16383, -16'sd16384, 16'sd512,
                    -16'sd1, 16'sd2048, -16'sd2048};
      corner_f1 = '{16'sd0, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, -16'sd1, 16'sd0,
                    16'sd4096, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, -16'sd512,
                    -16'sd1, 16'sd2048, 16'sd1024};
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_feature0 <= '0;
      req_feature1 <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            apply_setting(plan[p]);
         end
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         if (p == 0) begin
            for (int i = 0; i < 16; i++) begin
               send_features(corner_f0[i], corner_f1[i]);
            end
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // With no idling the long hold-off lets the block fill and push back.
            if (p % 4 == 0 && k == 40) begin
               hold_left = HOLD_CYCLES;
            end
            send_features(draw_feature(), draw_feature());
         end
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (book.errors == 0 && book.pending_score.size() == 0) begin
         $display("tiny_mlp_classifier_core: match");
      end else begin
         $display("tiny_mlp_classifier_core: mismatch");
      end
      $finish;
   end

endmodule
